// ===== sv/mtnp_pkg.sv =====
// mtnp_pkg: shared types and character codes for the melody text note parser
// no dependencies; used by the parser core and the testbench
package mtnp_pkg;

    localparam int CHAR_W       = 8;
    localparam int NOTE_W       = 8;
    localparam int PHRASE_LEN_W = 24;

    localparam logic [CHAR_W-1:0] ASCII_0     = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_9     = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] ASCII_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] ASCII_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] ASCII_A     = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_B     = 8'h42;
    localparam logic [CHAR_W-1:0] ASCII_C     = 8'h43;
    localparam logic [CHAR_W-1:0] ASCII_D     = 8'h44;
    localparam logic [CHAR_W-1:0] ASCII_E     = 8'h45;
    localparam logic [CHAR_W-1:0] ASCII_F     = 8'h46;
    localparam logic [CHAR_W-1:0] ASCII_G     = 8'h47;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              line_end;
    } char_beat_t;

    typedef struct packed {
        logic                    note_valid;
        logic [NOTE_W-1:0]       note_number;
        logic                    phrase_done;
        logic [PHRASE_LEN_W-1:0] phrase_len;
        logic                    malformed;
    } note_beat_t;

endpackage

// ===== sv/mtnp_stream_if.sv =====
// mtnp_stream_if: valid/ready stream channel carrying one payload beat
// payload type is set per instance, normally a struct from mtnp_pkg
interface mtnp_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/melody_text_note_parser_core.sv =====
// melody_text_note_parser_core: melody text line parser with iterative divider
// depends on mtnp_pkg and mtnp_stream_if
//
// Usage:
//   chars : sink channel, one character beat (char_code, line_end) per beat.
//   notes : source channel, one result beat for every completed note and one
//           at every line end (phrase_done, phrase_len, malformed).
//   wr_en / wr_data : writes duration_numerator; the user writes it only while
//           the block is idle, which the block itself does not enforce.
// Flow: a character (or line end) that closes a nonzero duration number starts
// the shared restoring divider: a multiply step, an overflow compare step,
// LENGTH_WIDTH subtract steps (skipped when the quotient saturates) and an
// accumulate step. No further character is taken until the divider is idle
// again; other characters are taken without involving the divider.
// Latency: a result beat is registered and valid the cycle after the character
// is taken, or after the accumulate cycle when a division was pending.
// Reset: parser state, phrase length and error clear, duration_numerator
// returns to 32, no beat is pending. There is no clearing pass.
// Stall: a waiting result beat is held in the output register; chars.ready
// is high in idle while that beat can drain in the same cycle, otherwise low.
module melody_text_note_parser_core #(
    parameter int FRACTION_DIGITS = 3,
    parameter int LENGTH_WIDTH    = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [7:0]                   wr_data,
    mtnp_stream_if.sink                  chars,
    mtnp_stream_if.source                notes
);

    localparam int MANT_W = 20;
    localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};
    localparam int FC_W   = 3;
    localparam int NUM_W  = 8;
    localparam int LW     = LENGTH_WIDTH;

    // token phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_TOKEN = 2'd1;
    localparam logic [1:0] PH_OCT   = 2'd2;
    localparam logic [1:0] PH_OFRAC = 2'd3;

    function automatic logic [19:0] pow10(input logic [FC_W-1:0] n);
        logic [19:0] v;
        case (n)
            3'd0:    v = 20'd1;
            3'd1:    v = 20'd10;
            3'd2:    v = 20'd100;
            3'd3:    v = 20'd1000;
            3'd4:    v = 20'd10000;
            3'd5:    v = 20'd100000;
            default: v = 20'd1000000;
        endcase
        return v;
    endfunction

    localparam int POW_W  = $clog2(int'(pow10(FC_W'(FRACTION_DIGITS))) + 1);
    localparam int PROD_W = NUM_W + POW_W;
    localparam int TOP_W  = PROD_W + 8;
    localparam int SPAN_W = (TOP_W > MANT_W) ? TOP_W : MANT_W;
    localparam int WIDE_W = SPAN_W + LW;
    localparam int CNT_W  = $clog2(LW);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_CHK  = 5'b00100,
        S_DIV  = 5'b01000,
        S_ADD  = 5'b10000
    } state_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] semi;
    } letter_t;

    function automatic letter_t note_letter(input logic [7:0] c);
        letter_t r;
        r.hit = 1'b1;
        unique case (c)
            mtnp_pkg::ASCII_C: r.semi = 5'd0;
            mtnp_pkg::ASCII_D: r.semi = 5'd2;
            mtnp_pkg::ASCII_E: r.semi = 5'd4;
            mtnp_pkg::ASCII_F: r.semi = 5'd5;
            mtnp_pkg::ASCII_G: r.semi = 5'd7;
            mtnp_pkg::ASCII_A: r.semi = 5'd9;
            mtnp_pkg::ASCII_B: r.semi = 5'd11;
            default:
            begin
                r.hit  = 1'b0;
                r.semi = 5'd0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] note_code(input logic [4:0] s, input logic [7:0] o);
        return {{3{s[4]}}, s} + (o << 3) + (o << 2);
    endfunction

    state_t               state_reg, state_next;
    logic [NUM_W-1:0]     num_reg;
    logic                 comma_reg, comma_next;
    logic [1:0]           phase_reg, phase_next;
    logic [4:0]           semi_reg, semi_next;
    logic [7:0]           oct_reg, oct_next;
    logic [MANT_W-1:0]    mant_reg, mant_next;
    logic [FC_W-1:0]      fc_reg, fc_next;
    logic                 point_reg, point_next;
    logic [LW-1:0]        len_reg, len_next;
    logic                 err_reg, err_next;
    logic                 pend_end_reg, pend_end_next;
    logic [MANT_W-1:0]    div_m_reg, div_m_next;
    logic [FC_W-1:0]      div_fc_reg, div_fc_next;
    logic [TOP_W-1:0]     top_reg, top_next;
    logic [MANT_W-1:0]    rem_reg, rem_next;
    logic [LW-1:0]        dq_reg, dq_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg;
    mtnp_pkg::note_beat_t out_data_reg;

    logic                 out_load;
    mtnp_pkg::note_beat_t out_load_data;
    logic                 chars_acc;
    logic [7:0]           c;
    logic [3:0]           dig;
    logic                 is_digit;
    logic                 fin_body, fin_end, fin_any, fin_zero;
    logic [MANT_W-1:0]    fin_body_m, fin_end_m;
    logic [FC_W-1:0]      fin_body_fc, fin_end_fc;
    logic                 emit;
    logic [7:0]           note_val;
    logic [23:0]          mant_ext;
    letter_t              letter;
    logic [WIDE_W-1:0]    top_wide, m_wide;
    logic [MANT_W:0]      r_try;
    logic                 r_ge;
    logic [LW:0]          len_sum;
    logic [LW-1:0]        len_sat;

    assign chars.ready = (state_reg == S_IDLE) && (!out_valid_reg || notes.ready);
    assign chars_acc   = chars.valid && chars.ready;
    assign notes.valid = out_valid_reg;
    assign notes.data  = out_data_reg;

    assign c        = chars.data.char_code;
    assign dig      = 4'(c - mtnp_pkg::ASCII_0);
    assign is_digit = (c >= mtnp_pkg::ASCII_0) && (c <= mtnp_pkg::ASCII_9);
    assign letter   = note_letter(c);

    assign top_wide = WIDE_W'(top_reg);
    assign m_wide   = WIDE_W'(div_m_reg) << LW;
    assign r_try    = {rem_reg, dq_reg[LW-1]};
    assign r_ge     = r_try >= {1'b0, div_m_reg};
    assign len_sum  = {1'b0, len_reg} + {1'b0, dq_reg};
    assign len_sat  = len_sum[LW] ? {LW{1'b1}} : len_sum[LW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        comma_next    = comma_reg;
        phase_next    = phase_reg;
        semi_next     = semi_reg;
        oct_next      = oct_reg;
        mant_next     = mant_reg;
        fc_next       = fc_reg;
        point_next    = point_reg;
        len_next      = len_reg;
        err_next      = err_reg;
        pend_end_next = pend_end_reg;
        div_m_next    = div_m_reg;
        div_fc_next   = div_fc_reg;
        top_next      = top_reg;
        rem_next      = rem_reg;
        dq_next       = dq_reg;
        cnt_next      = cnt_reg;
        fin_body      = 1'b0;
        fin_end       = 1'b0;
        fin_body_m    = '0;
        fin_end_m     = '0;
        fin_body_fc   = '0;
        fin_end_fc    = '0;
        fin_any       = 1'b0;
        fin_zero      = 1'b0;
        emit          = 1'b0;
        note_val      = '0;
        mant_ext      = '0;
        out_load      = 1'b0;
        out_load_data = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (chars_acc)
                begin
                    if (!comma_next)
                    begin
                        if (is_digit)
                        begin
                            mant_ext = (24'(mant_next) << 3) + (24'(mant_next) << 1) + 24'(dig);
                            if (!point_next || (fc_next < FC_W'(FRACTION_DIGITS)))
                            begin
                                if (point_next)
                                    fc_next = fc_next + 1'b1;
                                mant_next = (mant_ext > 24'(MANT_MAX)) ? MANT_MAX
                                                                       : MANT_W'(mant_ext);
                            end
                            phase_next = PH_TOKEN;
                        end
                        else if (c == mtnp_pkg::ASCII_POINT)
                        begin
                            // a second point closes the number and opens a new one
                            if (phase_next == PH_TOKEN && point_next)
                            begin
                                fin_body    = 1'b1;
                                fin_body_m  = mant_next;
                                fin_body_fc = fc_next;
                                mant_next   = '0;
                                fc_next     = '0;
                            end
                            phase_next = PH_TOKEN;
                            point_next = 1'b1;
                        end
                        else
                        begin
                            if (phase_next == PH_TOKEN)
                            begin
                                fin_body    = 1'b1;
                                fin_body_m  = mant_next;
                                fin_body_fc = fc_next;
                                mant_next   = '0;
                                fc_next     = '0;
                                point_next  = 1'b0;
                                phase_next  = PH_IDLE;
                            end
                            if (c == mtnp_pkg::ASCII_COMMA)
                                comma_next = 1'b1;
                            else if (c != mtnp_pkg::ASCII_SPACE)
                                err_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (phase_next == PH_TOKEN)
                        begin
                            if (is_digit)
                                oct_next = 8'(dig);
                            else
                            begin
                                semi_next = semi_next +
                                    ((c == mtnp_pkg::ASCII_HASH) ? 5'd1 : 5'd31);
                                oct_next  = '0;
                            end
                            phase_next = PH_OCT;
                        end
                        else if ((phase_next == PH_OCT || phase_next == PH_OFRAC) && is_digit)
                        begin
                            if (phase_next == PH_OCT)
                                oct_next = (oct_next << 3) + (oct_next << 1) + 8'(dig);
                        end
                        else if (phase_next == PH_OCT && c == mtnp_pkg::ASCII_POINT)
                            phase_next = PH_OFRAC;
                        else
                        begin
                            if (phase_next == PH_OCT || phase_next == PH_OFRAC)
                            begin
                                emit       = 1'b1;
                                note_val   = note_code(semi_next, oct_next);
                                phase_next = PH_IDLE;
                            end
                            if (c != mtnp_pkg::ASCII_SPACE)
                            begin
                                if (letter.hit)
                                begin
                                    semi_next  = letter.semi;
                                    oct_next   = '0;
                                    phase_next = PH_TOKEN;
                                end
                                else
                                    err_next = 1'b1;
                            end
                        end
                    end

                    if (chars.data.line_end)
                    begin
                        if (!comma_next)
                        begin
                            if (phase_next == PH_TOKEN)
                            begin
                                fin_end    = 1'b1;
                                fin_end_m  = mant_next;
                                fin_end_fc = fc_next;
                            end
                            err_next = 1'b1;
                        end
                        else if (phase_next == PH_TOKEN)
                            err_next = 1'b1;
                        else if (phase_next == PH_OCT || phase_next == PH_OFRAC)
                        begin
                            emit     = 1'b1;
                            note_val = note_code(semi_next, oct_next);
                        end
                    end

                    // a zero duration saturates the length, so any other term is moot
                    fin_any  = fin_body || fin_end;
                    fin_zero = (fin_body && fin_body_m == '0) || (fin_end && fin_end_m == '0);
                    if (fin_any && fin_zero)
                    begin
                        len_next = {LW{1'b1}};
                        err_next = 1'b1;
                    end
                    else if (fin_any)
                    begin
                        div_m_next    = fin_end ? fin_end_m : fin_body_m;
                        div_fc_next   = fin_end ? fin_end_fc : fin_body_fc;
                        pend_end_next = chars.data.line_end;
                        state_next    = S_MUL;
                    end

                    if (chars.data.line_end && !(fin_any && !fin_zero))
                    begin
                        out_load                  = 1'b1;
                        out_load_data.note_valid  = emit;
                        out_load_data.note_number = emit ? note_val : '0;
                        out_load_data.phrase_done = 1'b1;
                        out_load_data.phrase_len  = mtnp_pkg::PHRASE_LEN_W'(len_next);
                        out_load_data.malformed   = err_next;
                        len_next                  = '0;
                        err_next                  = 1'b0;
                    end
                    else if (emit)
                    begin
                        out_load                  = 1'b1;
                        out_load_data.note_valid  = 1'b1;
                        out_load_data.note_number = note_val;
                    end

                    if (chars.data.line_end)
                    begin
                        comma_next = 1'b0;
                        phase_next = PH_IDLE;
                        semi_next  = '0;
                        oct_next   = '0;
                        mant_next  = '0;
                        fc_next    = '0;
                        point_next = 1'b0;
                    end
                end
            end
            S_MUL:
            begin
                top_next   = {PROD_W'(num_reg) * PROD_W'(pow10(div_fc_reg)), 8'b0};
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // quotient of more than LW bits saturates
                if (top_wide >= m_wide)
                begin
                    dq_next    = {LW{1'b1}};
                    state_next = S_ADD;
                end
                else
                begin
                    rem_next   = MANT_W'(top_wide >> LW);
                    dq_next    = LW'(top_wide);
                    cnt_next   = CNT_W'(LW - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = r_ge ? MANT_W'(r_try - {1'b0, div_m_reg}) : MANT_W'(r_try);
                dq_next  = {dq_reg[LW-2:0], r_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                if (!pend_end_reg)
                begin
                    len_next   = len_sat;
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || notes.ready)
                begin
                    out_load                  = 1'b1;
                    out_load_data.phrase_done = 1'b1;
                    out_load_data.phrase_len  = mtnp_pkg::PHRASE_LEN_W'(len_sat);
                    out_load_data.malformed   = err_reg;
                    len_next                  = '0;
                    err_next                  = 1'b0;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_reg       <= NUM_W'(32);
            comma_reg     <= 1'b0;
            phase_reg     <= PH_IDLE;
            semi_reg      <= '0;
            oct_reg       <= '0;
            mant_reg      <= '0;
            fc_reg        <= '0;
            point_reg     <= 1'b0;
            len_reg       <= '0;
            err_reg       <= 1'b0;
            pend_end_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (wr_en)
                num_reg <= wr_data;
            comma_reg    <= comma_next;
            phase_reg    <= phase_next;
            semi_reg     <= semi_next;
            oct_reg      <= oct_next;
            mant_reg     <= mant_next;
            fc_reg       <= fc_next;
            point_reg    <= point_next;
            len_reg      <= len_next;
            err_reg      <= err_next;
            pend_end_reg <= pend_end_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (notes.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // divider datapath and result beat, no reset needed
    always_ff @(posedge clk)
    begin
        div_m_reg  <= div_m_next;
        div_fc_reg <= div_fc_next;
        top_reg    <= top_next;
        rem_reg    <= rem_next;
        dq_reg     <= dq_next;
        cnt_reg    <= cnt_next;
        if (out_load)
            out_data_reg <= out_load_data;
    end

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg != '0) |=>
            (state_reg == S_DIV && cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("divider step count broken");

    a_chk_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |=> (state_reg == S_DIV || state_reg == S_ADD))
        else $error("overflow check did not branch to divide or accumulate");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < div_m_reg))
        else $error("partial remainder not below divisor");

    a_mid_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.phrase_done) |->
            (out_data_reg.note_valid && out_data_reg.phrase_len == '0
             && !out_data_reg.malformed))
        else $error("note beat carries phrase fields");

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for melody_text_note_parser_core, driving melody text lines
// depends on mtnp_pkg, mtnp_stream_if and the parser core; a scoreboard class predicts each beat
`timescale 1ns / 100ps

module tb;

    localparam int FRACTION_DIGITS = 3;
    localparam int LENGTH_WIDTH    = 24;
    localparam logic [63:0] LENGTH_MAX = (64'd1 << LENGTH_WIDTH) - 1;
    localparam int LIMIT_CYCLES    = 400_000;
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_CHARS    = 1200;
    localparam int PHASES          = 5;

    // token phase: between tokens, open number or letter, octave digits, octave fraction
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_OPEN     = 3'd1;
    localparam logic [2:0] PH_OCTAVE   = 3'd2;
    localparam logic [2:0] PH_OCT_FRAC = 3'd3;

    // receiver stall patterns
    localparam int RX_OPEN     = 0;
    localparam int RX_MOSTLY   = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    typedef logic [7:0] byte_q_t[$];

    class note_scoreboard;
        logic [7:0]              numerator;
        bit                      after_comma;
        logic [2:0]              phase;
        logic [4:0]              semitone;
        logic [7:0]              octave;
        logic [19:0]             mantissa;
        logic [2:0]              frac_digits;
        bit                      point_seen;
        logic [LENGTH_WIDTH-1:0] length_sum;
        bit                      line_bad;
        mtnp_pkg::note_beat_t    due_beats[$];
        int                      errors;

        function new();
            numerator = 8'd32;
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            after_comma = 1'b0;
            phase       = PH_IDLE;
            semitone    = '0;
            octave      = '0;
            mantissa    = '0;
            frac_digits = '0;
            point_seen  = 1'b0;
            length_sum  = '0;
            line_bad    = 1'b0;
        endfunction

        function int pending();
            return due_beats.size();
        endfunction

        // adds numerator * 10^frac * 256 / mantissa to the phrase length; a zero mantissa saturates it
        function void close_number();
            logic [63:0] quot;
            logic [63:0] total;
            if (mantissa == '0)
            begin
                length_sum = '1;
                line_bad = 1'b1;
            end
            else
            begin
                quot = 64'(numerator);
                repeat (frac_digits) quot = quot * 10;
                quot = (quot << 8) / mantissa;
                if (quot > LENGTH_MAX)
                    quot = LENGTH_MAX;
                total = 64'(length_sum) + quot;
                length_sum = (total > LENGTH_MAX) ? '1 : total[LENGTH_WIDTH-1:0];
            end
            mantissa    = '0;
            frac_digits = '0;
            point_seen  = 1'b0;
            phase       = PH_IDLE;
        endfunction

        // semitone is 5-bit two's complement, so a lowered C goes below zero
        function logic [7:0] pitch_now();
            return {{3{semitone[4]}}, semitone} + octave * 8'd12;
        endfunction

        function void take_char(mtnp_pkg::char_beat_t b);
            logic [7:0]           c;
            logic [63:0]          grown;
            logic [7:0]           note;
            bit                   digit;
            bit                   emit;
            bit                   letter;
            mtnp_pkg::note_beat_t r;
            c = b.char_code;
            digit = (c >= mtnp_pkg::ASCII_0) && (c <= mtnp_pkg::ASCII_9);
            emit = 1'b0;
            note = '0;
            if (!after_comma)
            begin
                if (digit)
                begin
                    if (!point_seen || frac_digits < FRACTION_DIGITS)
                    begin
                        if (point_seen)
                            frac_digits++;
                        grown = 64'(mantissa) * 10 + 64'(c - mtnp_pkg::ASCII_0);
                        mantissa = (grown > 64'hFFFFF) ? 20'hFFFFF : grown[19:0];
                    end
                    phase = PH_OPEN;
                end
                else if (c == mtnp_pkg::ASCII_POINT)
                begin
                    if (phase == PH_OPEN && point_seen)
                        close_number();
                    phase = PH_OPEN;
                    point_seen = 1'b1;
                end
                else
                begin
                    if (phase == PH_OPEN)
                        close_number();
                    if (c == mtnp_pkg::ASCII_COMMA)
                        after_comma = 1'b1;
                    else if (c != mtnp_pkg::ASCII_SPACE)
                        line_bad = 1'b1;
                end
            end
            else
            begin
                if (phase == PH_OPEN)
                begin
                    // first char after the letter: digit starts the octave, else accidental
                    if (digit)
                        octave = c - mtnp_pkg::ASCII_0;
                    else
                    begin
                        semitone = semitone + ((c == mtnp_pkg::ASCII_HASH) ? 5'd1 : 5'd31);
                        octave = '0;
                    end
                    phase = PH_OCTAVE;
                end
                else if (phase >= PH_OCTAVE && digit)
                begin
                    if (phase == PH_OCTAVE)
                        octave = octave * 8'd10 + (c - mtnp_pkg::ASCII_0);
                end
                else if (phase == PH_OCTAVE && c == mtnp_pkg::ASCII_POINT)
                    phase = PH_OCT_FRAC;
                else
                begin
                    if (phase >= PH_OCTAVE)
                    begin
                        emit = 1'b1;
                        note = pitch_now();
                        phase = PH_IDLE;
                    end
                    if (c != mtnp_pkg::ASCII_SPACE)
                    begin
                        letter = 1'b1;
                        case (c)
                            mtnp_pkg::ASCII_C: semitone = 5'd0;
                            mtnp_pkg::ASCII_D: semitone = 5'd2;
                            mtnp_pkg::ASCII_E: semitone = 5'd4;
                            mtnp_pkg::ASCII_F: semitone = 5'd5;
                            mtnp_pkg::ASCII_G: semitone = 5'd7;
                            mtnp_pkg::ASCII_A: semitone = 5'd9;
                            mtnp_pkg::ASCII_B: semitone = 5'd11;
                            default: letter = 1'b0;
                        endcase
                        if (letter)
                        begin
                            octave = '0;
                            phase = PH_OPEN;
                        end
                        else
                            line_bad = 1'b1;
                    end
                end
            end

            r = '0;
            if (b.line_end)
            begin
                if (!after_comma)
                begin
                    if (phase == PH_OPEN)
                        close_number();
                    line_bad = 1'b1;
                end
                else if (phase == PH_OPEN)
                    line_bad = 1'b1;
                else if (phase >= PH_OCTAVE)
                begin
                    emit = 1'b1;
                    note = pitch_now();
                end
                r.note_valid  = emit;
                r.note_number = emit ? note : '0;
                r.phrase_done = 1'b1;
                r.phrase_len  = length_sum;
                r.malformed   = line_bad;
                due_beats.insert(due_beats.size(), r);
                clear_line();
            end
            else if (emit)
            begin
                r.note_valid  = 1'b1;
                r.note_number = note;
                due_beats.insert(due_beats.size(), r);
            end
        endfunction

        function void check_beat(mtnp_pkg::note_beat_t got);
            mtnp_pkg::note_beat_t want;
            if (due_beats.size() == 0)
            begin
                $error("result beat with nothing expected: %p", got);
                errors++;
                return;
            end
            want = due_beats.pop_front();
            if (got.note_valid !== want.note_valid)
            begin
                $error("note_valid: expected %0d, actual %0d", want.note_valid, got.note_valid);
                errors++;
            end
            if (got.note_number !== want.note_number)
            begin
                $error("note_number: expected %0d, actual %0d", want.note_number,
                       got.note_number);
                errors++;
            end
            if (got.phrase_done !== want.phrase_done)
            begin
                $error("phrase_done: expected %0d, actual %0d", want.phrase_done,
                       got.phrase_done);
                errors++;
            end
            if (got.phrase_len !== want.phrase_len)
            begin
                $error("phrase_len: expected %0h, actual %0h", want.phrase_len,
                       got.phrase_len);
                errors++;
            end
            if (got.malformed !== want.malformed)
            begin
                $error("malformed: expected %0d, actual %0d", want.malformed, got.malformed);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       wr_en;
    logic [7:0] wr_data;
    bit         hold_req = 1'b0;
    int         burst_left;
    int         sent_chars = 0;
    int         cycles = 0;

    note_scoreboard sb = new();

    mtnp_stream_if #(.payload_t(mtnp_pkg::char_beat_t)) chars_if ();
    mtnp_stream_if #(.payload_t(mtnp_pkg::note_beat_t)) notes_if ();

    melody_text_note_parser_core #(
        .FRACTION_DIGITS(FRACTION_DIGITS),
        .LENGTH_WIDTH   (LENGTH_WIDTH)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (wr_en),
        .wr_data(wr_data),
        .chars  (chars_if),
        .notes  (notes_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (chars_if.valid && chars_if.ready)
                sb.take_char(chars_if.data);
            if (notes_if.valid && notes_if.ready)
                sb.check_beat(notes_if.data);
        end
    end

    // receiver: changing stall patterns, plus one long hold-off on request
    initial
    begin : receiver
        int mode;
        int span;
        notes_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                notes_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            mode = $urandom_range(RX_OPEN, RX_PERIODIC);
            span = $urandom_range(16, 160);
            for (int k = 0; k < span && !hold_req; k++)
            begin
                case (mode)
                    RX_OPEN:   notes_if.ready <= 1'b1;
                    RX_MOSTLY: notes_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: notes_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   notes_if.ready <= k[1];
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void add_byte(ref byte_q_t t, input logic [7:0] b);
        t.insert(t.size(), b);
    endfunction

    function automatic void add_digits(ref byte_q_t t, input int n);
        repeat (n) add_byte(t, pick("0123456789"));
    endfunction

    function automatic void add_text(ref byte_q_t t, input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(t, s[i]);
    endfunction

    // sender works in bursts; valid stays high across back-to-back beats
    task automatic send_char(input logic [7:0] c, input logic last);
        mtnp_pkg::char_beat_t beat;
        beat.char_code = c;
        beat.line_end  = last;
        chars_if.valid <= 1'b1;
        chars_if.data  <= beat;
        @(posedge clk);
        while (!chars_if.ready) @(posedge clk);
        sent_chars++;
        if (burst_left == 0)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
        else
            burst_left--;
    endtask

    task automatic send_text(input byte_q_t t);
        foreach (t[i])
            send_char(t[i], i == t.size() - 1);
    endtask

    // wait until every beat is back, then let a pending division finish
    task automatic settle();
        chars_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (LENGTH_WIDTH + 8) @(posedge clk);
    endtask

    task automatic write_numerator(input logic [7:0] v);
        wr_en   <= 1'b1;
        wr_data <= v;
        sb.numerator = v;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    initial
    begin
        byte_q_t t;
        int      base;
        int      n_dur;
        int      n_notes;
        int      int_len;
        chars_if.valid <= 1'b0;
        chars_if.data  <= '0;
        wr_en          <= 1'b0;
        wr_data        <= '0;
        burst_left = $urandom_range(1, 16);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // second point, zero duration, raised note, octave wrap and fraction,
        // lowered note, bare letter at line end
        add_text(t, "1.5.25 0,B#99.7 Ex A");
        send_text(t);
        // stray top byte before the comma
        t.delete();
        add_text(t, "8");
        add_byte(t, 8'hFF);
        send_text(t);
        t = '{8'h00};
        send_text(t);
        // saturated mantissa, extra fraction digits, line ends before the comma
        t.delete();
        add_text(t, "9999999.9999");
        send_text(t);

        base = sent_chars;
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_numerator(p == 0 ? 8'd255 : p == 1 ? 8'd1 : 8'($urandom_range(1, 255)));
            if (p == 1)
                hold_req = 1'b1;
            while (sent_chars - base < (p + 1) * RANDOM_CHARS / PHASES)
            begin
                t.delete();
                if ($urandom_range(0, 6) == 0)
                begin
                    // noise: raw bytes mixed with characters the parser reacts to
                    repeat ($urandom_range(1, 10))
                        add_byte(t, $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                         : pick("0123456789., #ABCDEFGx"));
                end
                else
                begin
                    n_dur = $urandom_range(0, 3);
                    for (int i = 0; i < n_dur; i++)
                    begin
                        if (i > 0)
                            repeat ($urandom_range(1, 2)) add_byte(t, mtnp_pkg::ASCII_SPACE);
                        int_len = ($urandom_range(0, 15) == 0) ? 7 : $urandom_range(0, 3);
                        add_digits(t, int_len);
                        if (int_len == 0 || $urandom_range(0, 1))
                        begin
                            add_byte(t, mtnp_pkg::ASCII_POINT);
                            add_digits(t, $urandom_range(0, 5));
                            if ($urandom_range(0, 9) == 0)
                            begin
                                add_byte(t, mtnp_pkg::ASCII_POINT);
                                add_digits(t, $urandom_range(0, 3));
                            end
                        end
                    end
                    if ($urandom_range(0, 19) != 0)
                        add_byte(t, mtnp_pkg::ASCII_COMMA);
                    n_notes = $urandom_range(0, 4);
                    for (int i = 0; i < n_notes; i++)
                    begin
                        if (i > 0 || $urandom_range(0, 3) == 0)
                            add_byte(t, mtnp_pkg::ASCII_SPACE);
                        add_byte(t, pick("CDEFGAB"));
                        case ($urandom_range(0, 5))
                            3: add_byte(t, mtnp_pkg::ASCII_HASH);
                            4: add_byte(t, pick("bx- "));
                            default: ;
                        endcase
                        add_digits(t, ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2));
                        if ($urandom_range(0, 7) == 0)
                        begin
                            add_byte(t, mtnp_pkg::ASCII_POINT);
                            add_digits(t, $urandom_range(0, 2));
                        end
                    end
                    if (t.size() == 0)
                        add_byte(t, mtnp_pkg::ASCII_COMMA);
                end
                send_text(t);
            end
        end

        settle();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== melody_text_note_parser_core.f =====
sv/mtnp_pkg.sv
sv/mtnp_stream_if.sv
sv/melody_text_note_parser_core.sv
test/tb.sv
